[src/psy_pkg.sv]
package psy_pkg;

  localparam int DEF_THREAD_COUNT    = 16;
  localparam int DEF_PRIORITY_LEVELS = 8;
  localparam int ID_W                = 4;
  localparam int PRI_W               = 3;
  localparam int LIMIT_W             = 3;
  localparam int FIFO_DEPTH          = 2;

  localparam logic [LIMIT_W-1:0] RUN_LIMIT_RST = 3'd5;

  localparam logic [2:0] CMD_START     = 3'd0;
  localparam logic [2:0] CMD_READY     = 3'd1;
  localparam logic [2:0] CMD_PREEMPTED = 3'd2;
  localparam logic [2:0] CMD_WAITING   = 3'd3;
  localparam logic [2:0] CMD_SCHEDULE  = 3'd4;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_REJECT = 2'd1;
  localparam logic [1:0] STAT_EMPTY  = 2'd2;

  typedef struct packed {
    logic [2:0]       command;
    logic [ID_W-1:0]  thread_id;
    logic [PRI_W-1:0] priority_req;
  } psy_in_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] chosen_thread;
  } psy_out_t;

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_REJECT = 3'd1,
    OP_READY  = 3'd2,
    OP_WAIT   = 3'd3,
    OP_SCHED  = 3'd4,
    OP_NOP    = 3'd5
  } psy_op_t;

  typedef struct packed {
    psy_op_t          op;
    logic [ID_W-1:0]  thread_id;
    logic [PRI_W-1:0] priority_req;
  } psy_op_beat_t;

endpackage

[src/psy_front.sv]
module psy_front import psy_pkg::*; #(
  parameter int THREAD_COUNT    = DEF_THREAD_COUNT,
  parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS
) (
  input  logic         in_valid,
  output logic         in_stall,
  input  psy_in_t      in_data,
  input  logic         q_full,
  output logic         q_push,
  output psy_op_beat_t q_data
);

  logic tid_ok;
  logic pri_ok;

  assign tid_ok   = int'(in_data.thread_id) < THREAD_COUNT;
  assign pri_ok   = int'(in_data.priority_req) < PRIORITY_LEVELS;
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.thread_id    = in_data.thread_id;
    q_data.priority_req = in_data.priority_req;
    unique case (in_data.command)
      CMD_START:     q_data.op = (tid_ok && pri_ok) ? OP_START : OP_REJECT;
      CMD_READY,
      CMD_PREEMPTED: q_data.op = tid_ok ? OP_READY : OP_NOP;
      CMD_WAITING:   q_data.op = tid_ok ? OP_WAIT : OP_NOP;
      CMD_SCHEDULE:  q_data.op = OP_SCHED;
      default:       q_data.op = OP_NOP;
    endcase
  end

endmodule

[src/psy_op_fifo.sv]
module psy_op_fifo import psy_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  psy_op_beat_t push_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output psy_op_beat_t pop_data
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  psy_op_beat_t    slot_r [FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full      = cnt_r == CW'(FIFO_DEPTH);
  assign not_empty = cnt_r != '0;
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == FIFO_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == FIFO_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[src/psy_back.sv]
module psy_back import psy_pkg::*; #(
  parameter int THREAD_COUNT    = DEF_THREAD_COUNT,
  parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               op_valid,
  input  psy_op_beat_t       op_data,
  output logic               op_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output psy_out_t           out_data,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data
);

  // only ids below 16 can ever be named
  localparam int SLOTS = (THREAD_COUNT < (1 << ID_W)) ? THREAD_COUNT : (1 << ID_W);
  localparam int SW    = $clog2(SLOTS);
  localparam int LW    = $clog2(PRIORITY_LEVELS);
  localparam int PW    = $clog2(THREAD_COUNT);
  localparam int CW    = $clog2(THREAD_COUNT + 1);
  localparam int QD    = PRIORITY_LEVELS * THREAD_COUNT;
  localparam int QAW   = $clog2(QD);

  typedef enum logic [1:0] {
    TS_UNUSED  = 2'd0,
    TS_READY   = 2'd1,
    TS_RUNNING = 2'd2,
    TS_WAITING = 2'd3
  } psy_tstate_t;

  typedef enum logic [1:0] {
    BS_IDLE  = 2'b01,
    BS_FETCH = 2'b10
  } psy_bstate_t;

  psy_bstate_t        state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  psy_out_t           out_data_r, out_data_nxt;
  logic [LIMIT_W-1:0] run_limit_r;

  psy_tstate_t        tstat_r  [SLOTS];
  psy_tstate_t        tstat_nxt[SLOTS];
  logic [LW-1:0]      tlvl_r   [SLOTS];
  logic [LW-1:0]      tlvl_nxt [SLOTS];

  logic [PW-1:0]      head_r   [PRIORITY_LEVELS];
  logic [PW-1:0]      head_nxt [PRIORITY_LEVELS];
  logic [PW-1:0]      tail_r   [PRIORITY_LEVELS];
  logic [PW-1:0]      tail_nxt [PRIORITY_LEVELS];
  logic [CW-1:0]      qcnt_r   [PRIORITY_LEVELS];
  logic [CW-1:0]      qcnt_nxt [PRIORITY_LEVELS];
  logic [LIMIT_W-1:0] rcnt_r   [PRIORITY_LEVELS];
  logic [LIMIT_W-1:0] rcnt_nxt [PRIORITY_LEVELS];

  logic [ID_W-1:0]    qmem [QD];
  logic [ID_W-1:0]    rd_data_r;

  logic               out_free;
  logic               take;
  logic [SW-1:0]      tid_idx;
  logic [SW-1:0]      run_idx;
  logic [LIMIT_W-1:0] limit_eff;
  logic [PRIORITY_LEVELS-1:0] nonempty;
  logic [PRIORITY_LEVELS-1:0] elig;
  logic               elig_any;
  logic               any_ready;
  logic [LW-1:0]      pick_lvl;
  logic [LW-1:0]      top_lvl;
  logic [LW-1:0]      sel_lvl;
  logic [LW-1:0]      op_lvl;
  logic [PW-1:0]      ptr_sel;
  logic [QAW-1:0]     qaddr;
  logic               mem_we;
  logic               mem_re;

  assign out_free  = !out_valid_r || !out_stall;
  assign take      = (state_r == BS_IDLE) && op_valid && out_free;
  assign op_pop    = take;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign tid_idx   = SW'(op_data.thread_id);
  assign run_idx   = SW'(rd_data_r);
  assign limit_eff = (run_limit_r == '0) ? LIMIT_W'(1) : run_limit_r;

  always_comb begin
    for (int j = 0; j < PRIORITY_LEVELS; j++) begin
      nonempty[j] = qcnt_r[j] != '0;
      elig[j]     = nonempty[j] && (rcnt_r[j] < limit_eff);
    end
  end

  assign elig_any  = |elig;
  assign any_ready = |nonempty;

  always_comb begin
    pick_lvl = '0;
    top_lvl  = '0;
    for (int j = 0; j < PRIORITY_LEVELS; j++) begin
      if (elig[j]) begin
        pick_lvl = LW'(j);
      end
      if (nonempty[j]) begin
        top_lvl = LW'(j);
      end
    end
  end

  // nothing eligible: every busy level yields, then the top busy level wins
  assign sel_lvl = elig_any ? pick_lvl : top_lvl;
  assign op_lvl  = (op_data.op == OP_SCHED) ? sel_lvl : tlvl_r[tid_idx];
  assign ptr_sel = (op_data.op == OP_SCHED) ? head_r[op_lvl] : tail_r[op_lvl];
  assign qaddr   = QAW'(op_lvl) * QAW'(THREAD_COUNT) + QAW'(ptr_sel);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    tstat_nxt     = tstat_r;
    tlvl_nxt      = tlvl_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    qcnt_nxt      = qcnt_r;
    rcnt_nxt      = rcnt_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    unique case (state_r)
      BS_IDLE: begin
        if (take) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = STAT_OK;
          out_data_nxt.chosen_thread = '0;
          unique case (op_data.op)
            OP_START: begin
              if (tstat_r[tid_idx] == TS_UNUSED) begin
                tstat_nxt[tid_idx] = TS_WAITING;
                tlvl_nxt[tid_idx]  = LW'(op_data.priority_req);
              end else begin
                out_data_nxt.status = STAT_REJECT;
              end
            end
            OP_REJECT: out_data_nxt.status = STAT_REJECT;
            OP_READY: begin
              tstat_nxt[tid_idx] = TS_READY;
              if (qcnt_r[op_lvl] != CW'(THREAD_COUNT)) begin
                mem_we           = 1'b1;
                tail_nxt[op_lvl] = (int'(tail_r[op_lvl]) == THREAD_COUNT - 1) ?
                                   '0 : tail_r[op_lvl] + 1'b1;
                qcnt_nxt[op_lvl] = qcnt_r[op_lvl] + 1'b1;
              end
            end
            OP_WAIT: tstat_nxt[tid_idx] = TS_WAITING;
            OP_SCHED: begin
              if (!any_ready) begin
                out_data_nxt.status = STAT_EMPTY;
              end else begin
                out_valid_nxt    = 1'b0;
                mem_re           = 1'b1;
                state_nxt        = BS_FETCH;
                head_nxt[op_lvl] = (int'(head_r[op_lvl]) == THREAD_COUNT - 1) ?
                                   '0 : head_r[op_lvl] + 1'b1;
                qcnt_nxt[op_lvl] = qcnt_r[op_lvl] - 1'b1;
                for (int j = 0; j < PRIORITY_LEVELS; j++) begin
                  if (elig_any) begin
                    if (j == int'(pick_lvl)) begin
                      rcnt_nxt[j] = rcnt_r[j] + 1'b1;
                    end else if (j > int'(pick_lvl) && nonempty[j]) begin
                      rcnt_nxt[j] = '0;
                    end
                  end else if (nonempty[j]) begin
                    rcnt_nxt[j] = (j == int'(top_lvl)) ? LIMIT_W'(1) : '0;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      BS_FETCH: begin
        tstat_nxt[run_idx]         = TS_RUNNING;
        out_valid_nxt              = 1'b1;
        out_data_nxt.status        = STAT_OK;
        out_data_nxt.chosen_thread = rd_data_r;
        state_nxt                  = BS_IDLE;
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      out_valid_r <= 1'b0;
      run_limit_r <= RUN_LIMIT_RST;
      for (int i = 0; i < SLOTS; i++) begin
        tstat_r[i] <= TS_UNUSED;
        tlvl_r[i]  <= '0;
      end
      for (int j = 0; j < PRIORITY_LEVELS; j++) begin
        head_r[j] <= '0;
        tail_r[j] <= '0;
        qcnt_r[j] <= '0;
        rcnt_r[j] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        run_limit_r <= cfg_data;
      end
      tstat_r <= tstat_nxt;
      tlvl_r  <= tlvl_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      qcnt_r  <= qcnt_nxt;
      rcnt_r  <= rcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      qmem[qaddr] <= op_data.thread_id;
    end
    if (mem_re) begin
      rd_data_r <= qmem[qaddr];
    end
  end

endmodule

[src/priority_scheduler_with_yield.sv]
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall   | in_data   (psy_in_t)
// out     | out | out_valid/out_stall | out_data  (psy_out_t)
// cfg     | in  | cfg_we              | cfg_data  (run limit)
//
// Back end: a schedule that picks a thread does the level scan and the single-port queue
// memory read in BS_IDLE, then answers from BS_FETCH; other commands answer from BS_IDLE.
// A 2-beat command queue sits between decode and the back end.
// Synchronous reset clears all control state; queue memory is not cleared.
// in_stall rises only when the command queue is full; out_stall holds the result register.
module priority_scheduler_with_yield import psy_pkg::*; #(
  parameter int THREAD_COUNT    = DEF_THREAD_COUNT,
  parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  psy_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output psy_out_t           out_data,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data
);

  logic         q_full;
  logic         q_push;
  psy_op_beat_t q_wdata;
  logic         q_pop;
  logic         q_not_empty;
  psy_op_beat_t q_rdata;

  psy_front #(
    .THREAD_COUNT    (THREAD_COUNT),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  psy_op_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_rdata)
  );

  psy_back #(
    .THREAD_COUNT    (THREAD_COUNT),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (q_not_empty),
    .op_data   (q_rdata),
    .op_pop    (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

endmodule

[src/psy_checker.sv]
module psy_checker import psy_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input psy_out_t out_data
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == STAT_OK || out_data.status == STAT_REJECT ||
                  out_data.status == STAT_EMPTY)
    else $error("illegal status code");

  a_chosen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STAT_OK |-> out_data.chosen_thread == '0)
    else $error("thread reported on failed command");

endmodule

bind priority_scheduler_with_yield psy_checker u_psy_checker (.*);
